[rtl/core/assert_macros.svh]
// assertion macros used by the port checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, off while reset is asserted
`define EDD_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked assertion, checked during reset as well
`define EDD_ASSERT_ALWAYS(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/core/edd_pkg.sv]
// shared constants and types of the error diffusion dither unit
package edd_pkg;

	localparam int MAX_WIDTH_DEF = 1024;
	localparam int ACC_BITS_DEF  = 24;

	localparam int PIX_W      = 16;
	localparam int IN_TDATA_W = 3 * PIX_W;
	localparam int CFG_AW     = 3;
	localparam int CFG_DW     = 40;

	localparam int NUM_TAPS = 12;
	localparam int DIV_BITS = 4;

	localparam logic [15:0] COEF_ROW0_RST    = 16'd7;
	localparam logic [39:0] COEF_ROW1_RST    = 40'd17105664;
	localparam logic [39:0] COEF_ROW2_RST    = 40'd0;
	localparam logic        USE_SHIFT_RST    = 1'b1;
	localparam logic [7:0]  DIVISOR_RST      = 8'd4;
	localparam logic [15:0] MAX_VALUE_RST    = 16'd255;
	localparam logic [10:0] IMAGE_WIDTH_RST  = 11'd640;
	localparam logic [15:0] IMAGE_HEIGHT_RST = 16'd480;

	typedef enum logic [CFG_AW-1:0] {
		CFG_COEF_ROW0    = 3'd0,
		CFG_COEF_ROW1    = 3'd1,
		CFG_COEF_ROW2    = 3'd2,
		CFG_USE_SHIFT    = 3'd3,
		CFG_DIVISOR      = 3'd4,
		CFG_MAX_VALUE    = 3'd5,
		CFG_IMAGE_WIDTH  = 3'd6,
		CFG_IMAGE_HEIGHT = 3'd7
	} cfg_idx_t;

endpackage

[rtl/core/error_diffusion_dither_unit.sv]
// error diffusion dither unit, 3x5 kernel, shared multiply and scale unit
//
// channel  dir  handshake           payload
// s_*      in   s_tvalid/s_tready   tdata: red, green, blue
// m_*      out  m_tvalid/m_tready   tdata: out_pixel, tlast: row_end, tuser: frame_end
// cfg_*    in   cfg_valid/cfg_ready cfg_addr: register index, cfg_data: value
//
// per pixel: load, then the taps in turn; a skipped tap is only decoded, an active one is multiplied,
// then shifted or divided and added, or dropped with a zero divisor in division mode; one shared
// multiplier and a 4-bit-per-cycle divider serve up to 12 taps, one after the other
// a row end also clears each stale column left beyond the current width
// after reset all 3*MAX_WIDTH entries of the error store are cleared, s_tready low
// a result waits in the output register while the next pixel is taken, a full one holds the pixel
module error_diffusion_dither_unit #(
	parameter int MAX_WIDTH = edd_pkg::MAX_WIDTH_DEF,
	parameter int ACC_BITS  = edd_pkg::ACC_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [edd_pkg::IN_TDATA_W-1:0] s_tdata,   // red, green, blue
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [edd_pkg::PIX_W-1:0]      m_tdata,   // out_pixel
	output logic                           m_tlast,
	output logic                           m_tuser,   // frame_end
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [edd_pkg::CFG_AW-1:0]     cfg_addr,
	input  logic [edd_pkg::CFG_DW-1:0]     cfg_data
);
	import edd_pkg::*;

	localparam int CW     = $clog2(MAX_WIDTH);
	localparam int WW     = $clog2(MAX_WIDTH + 1);
	localparam int DEPTH  = 3 * MAX_WIDTH;
	localparam int AW     = $clog2(DEPTH);
	localparam int PW     = ACC_BITS + 9;
	localparam int DW     = ((PW + DIV_BITS - 1) / DIV_BITS) * DIV_BITS;
	localparam int DSTEPS = DW / DIV_BITS;
	localparam int NW     = $clog2(DSTEPS + 1);

	typedef enum logic [8:0] {
		S_CLR_ALL = 9'b000000001,
		S_IDLE    = 9'b000000010,
		S_LOAD    = 9'b000000100,
		S_TAP     = 9'b000001000,
		S_SCALE   = 9'b000010000,
		S_DIV     = 9'b000100000,
		S_ADD     = 9'b001000000,
		S_ROWCLR  = 9'b010000000,
		S_DONE    = 9'b100000000
	} state_t;

	state_t state_q;

	logic [15:0] coef_row0_q;
	logic [39:0] coef_row1_q;
	logic [39:0] coef_row2_q;
	logic        use_shift_q;
	logic [7:0]  divisor_q;
	logic [15:0] max_value_q;
	logic [10:0] image_width_q;
	logic [15:0] image_height_q;

	logic [CW-1:0] col_q;
	logic [15:0]   row_q;
	logic [1:0]    row_sel_q;
	logic [WW-1:0] fill_q [3];

	logic [AW-1:0] clr_q;
	logic [15:0]   gray_q;
	logic signed [ACC_BITS:0] err_q;
	logic [15:0]   pix_q;
	logic          rend_q;
	logic          fend_q;
	logic [3:0]    tap_q;
	logic [AW-1:0] tap_addr_q;
	logic [1:0]    tap_buf_q;
	logic [WW-1:0] tap_fill_q;
	logic signed [PW-1:0] prod_q;
	logic signed [PW-1:0] d_q;
	logic [DW-1:0] dvd_q;
	logic [DW-1:0] quo_q;
	logic [7:0]    rem_q;
	logic          neg_q;
	logic [NW-1:0] cnt_q;
	logic [WW-1:0] j_q;

	logic                 out_valid_q;
	logic [PIX_W-1:0]     out_pixel_q;
	logic                 out_last_q;
	logic                 out_user_q;

	logic signed [ACC_BITS-1:0] mem [DEPTH];
	logic signed [ACC_BITS-1:0] rd_q;
	logic                       rd_en;
	logic [AW-1:0]              rd_addr;
	logic                       we;
	logic [AW-1:0]              wa;
	logic signed [ACC_BITS-1:0] wd;

	function automatic logic [AW-1:0] buf_base(input logic [1:0] b);
		logic [AW-1:0] r;
		case (b)
			2'd1:    r = AW'(MAX_WIDTH);
			2'd2:    r = AW'(2 * MAX_WIDTH);
			default: r = '0;
		endcase
		return r;
	endfunction

	function automatic logic [1:0] buf_next(input logic [1:0] b);
		return (b == 2'd2) ? 2'd0 : b + 2'd1;
	endfunction

	assign cfg_ready = 1'b1;
	assign m_tvalid  = out_valid_q;
	assign m_tdata   = out_pixel_q;
	assign m_tlast   = out_last_q;
	assign m_tuser   = out_user_q;
	assign s_tready  = (state_q == S_IDLE);

	// effective geometry
	logic [WW-1:0] w_eff;
	logic [15:0]   h_eff;
	always_comb begin
		if (image_width_q == '0) begin
			w_eff = WW'(1);
		end else if (int'(image_width_q) > MAX_WIDTH) begin
			w_eff = WW'(MAX_WIDTH);
		end else begin
			w_eff = WW'(image_width_q);
		end
		h_eff = (image_height_q == '0) ? 16'd1 : image_height_q;
	end

	logic next1_ok, next2_ok;
	assign next1_ok = (17'(row_q) + 17'd1) < 17'(h_eff);
	assign next2_ok = (17'(row_q) + 17'd2) < 17'(h_eff);

	logic [AW-1:0] cur_addr;
	assign cur_addr = buf_base(row_sel_q) + AW'(col_q);

	// gray conversion
	logic [15:0] red_i, green_i, blue_i, mn, mx, gray_c;
	always_comb begin
		red_i   = s_tdata[15:0];
		green_i = s_tdata[31:16];
		blue_i  = s_tdata[47:32];
		mn = red_i;
		mx = red_i;
		if (green_i < mn) mn = green_i;
		if (blue_i < mn)  mn = blue_i;
		if (green_i > mx) mx = green_i;
		if (blue_i > mx)  mx = blue_i;
		gray_c = 16'((17'(mn) + 17'(mx)) >> 1);
	end

	// threshold
	logic signed [ACC_BITS+1:0] sum_c, max_c, outv_c;
	logic                       rend_c, fend_c;
	always_comb begin
		sum_c  = $signed({{(ACC_BITS+2-16){1'b0}}, gray_q}) + (ACC_BITS+2)'(rd_q);
		max_c  = $signed({{(ACC_BITS+2-16){1'b0}}, max_value_q});
		outv_c = ((sum_c <<< 1) < max_c) ? '0 : max_c;
		rend_c = (WW'(col_q) + WW'(1)) >= w_eff;
		fend_c = rend_c && !next1_ok;
	end

	// tap decode
	logic          tap_ok;
	logic [7:0]    tap_w;
	logic [1:0]    tap_buf;
	logic [AW-1:0] tap_addr;
	logic [WW-1:0] tap_fill;
	always_comb begin
		int c;
		int k;
		logic rok;
		c = 0;
		k = 0;
		rok = 1'b1;
		if (tap_q < 4'd2) begin
			k = int'(tap_q);
			c = int'(col_q) + 1 + k;
			tap_buf = row_sel_q;
			tap_w = coef_row0_q[8*k +: 8];
		end else if (tap_q < 4'd7) begin
			k = int'(tap_q) - 2;
			c = int'(col_q) + k - 2;
			tap_buf = buf_next(row_sel_q);
			tap_w = coef_row1_q[8*k +: 8];
			rok = next1_ok;
		end else begin
			k = int'(tap_q) - 7;
			c = int'(col_q) + k - 2;
			tap_buf = buf_next(buf_next(row_sel_q));
			tap_w = coef_row2_q[8*k +: 8];
			rok = next2_ok;
		end
		tap_ok   = rok && (c >= 0) && (c < int'(w_eff)) && (tap_w != 8'd0);
		tap_addr = buf_base(tap_buf) + AW'(c);
		tap_fill = WW'(c + 1);
	end

	logic tap_last;
	assign tap_last = (tap_q == 4'(NUM_TAPS - 1));

	// divider step, DIV_BITS quotient bits per cycle
	logic [DW-1:0] dvd_nx, quo_nx;
	logic [7:0]    rem_nx;
	always_comb begin
		logic [8:0] r9;
		r9 = '0;
		dvd_nx = dvd_q;
		quo_nx = quo_q;
		rem_nx = rem_q;
		for (int i = 0; i < DIV_BITS; i++) begin
			r9 = {rem_nx, dvd_nx[DW-1]};
			dvd_nx = dvd_nx << 1;
			if (r9 >= {1'b0, divisor_q}) begin
				r9 = r9 - {1'b0, divisor_q};
				quo_nx = {quo_nx[DW-2:0], 1'b1};
			end else begin
				quo_nx = {quo_nx[DW-2:0], 1'b0};
			end
			rem_nx = r9[7:0];
		end
	end

	logic [PW-1:0] mag_c;
	logic [PW-1:0] q_res;
	assign mag_c = prod_q[PW-1] ? PW'(-prod_q) : PW'(prod_q);
	assign q_res = quo_nx[PW-1:0];

	// saturating accumulate
	logic signed [PW:0]         acc_sum;
	logic signed [ACC_BITS-1:0] acc_new;
	always_comb begin
		logic signed [PW:0] hi;
		logic signed [PW:0] lo;
		hi = $signed({{(PW+2-ACC_BITS){1'b0}}, {(ACC_BITS-1){1'b1}}});
		lo = $signed({{(PW+2-ACC_BITS){1'b1}}, {(ACC_BITS-1){1'b0}}});
		acc_sum = (PW+1)'(rd_q) + (PW+1)'(d_q);
		if (acc_sum > hi) begin
			acc_new = hi[ACC_BITS-1:0];
		end else if (acc_sum < lo) begin
			acc_new = lo[ACC_BITS-1:0];
		end else begin
			acc_new = acc_sum[ACC_BITS-1:0];
		end
	end

	logic [WW-1:0] fill_cur;
	logic          rowclr_go;
	logic          out_free;
	assign fill_cur  = fill_q[row_sel_q];
	assign rowclr_go = (j_q < fill_cur);
	assign out_free  = !out_valid_q || m_tready;

	// memory ports
	assign rd_en   = (state_q == S_IDLE) || (state_q == S_TAP);
	assign rd_addr = (state_q == S_IDLE) ? cur_addr : tap_addr;

	always_comb begin
		we = 1'b0;
		wa = '0;
		wd = '0;
		unique case (state_q)
			S_CLR_ALL: begin
				we = 1'b1;
				wa = clr_q;
			end
			S_LOAD: begin
				we = 1'b1;
				wa = cur_addr;
			end
			S_ADD: begin
				we = 1'b1;
				wa = tap_addr_q;
				wd = acc_new;
			end
			S_ROWCLR: begin
				we = rowclr_go;
				wa = buf_base(row_sel_q) + AW'(j_q);
			end
			default: begin
				we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wa] <= wd;
		end
		if (rd_en) begin
			rd_q <= mem[rd_addr];
		end
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_row0_q    <= COEF_ROW0_RST;
			coef_row1_q    <= COEF_ROW1_RST;
			coef_row2_q    <= COEF_ROW2_RST;
			use_shift_q    <= USE_SHIFT_RST;
			divisor_q      <= DIVISOR_RST;
			max_value_q    <= MAX_VALUE_RST;
			image_width_q  <= IMAGE_WIDTH_RST;
			image_height_q <= IMAGE_HEIGHT_RST;
		end else if (cfg_valid) begin
			unique case (cfg_idx_t'(cfg_addr))
				CFG_COEF_ROW0:    coef_row0_q    <= cfg_data[15:0];
				CFG_COEF_ROW1:    coef_row1_q    <= cfg_data[39:0];
				CFG_COEF_ROW2:    coef_row2_q    <= cfg_data[39:0];
				CFG_USE_SHIFT:    use_shift_q    <= cfg_data[0];
				CFG_DIVISOR:      divisor_q      <= cfg_data[7:0];
				CFG_MAX_VALUE:    max_value_q    <= cfg_data[15:0];
				CFG_IMAGE_WIDTH:  image_width_q  <= cfg_data[10:0];
				CFG_IMAGE_HEIGHT: image_height_q <= cfg_data[15:0];
			endcase
		end
	end

	// sequencer and datapath registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLR_ALL;
			clr_q       <= '0;
			col_q       <= '0;
			row_q       <= '0;
			row_sel_q   <= '0;
			for (int b = 0; b < 3; b++) begin
				fill_q[b] <= '0;
			end
			tap_q       <= '0;
			j_q         <= '0;
			cnt_q       <= '0;
			rend_q      <= 1'b0;
			fend_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			out_valid_q <= (out_valid_q && !m_tready) || ((state_q == S_DONE) && out_free);
			unique case (state_q)
				S_CLR_ALL: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == AW'(DEPTH - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (s_tvalid) begin
						gray_q  <= gray_c;
						state_q <= S_LOAD;
					end
				end
				S_LOAD: begin
					err_q   <= (ACC_BITS+1)'(sum_c - outv_c);
					pix_q   <= outv_c[15:0];
					rend_q  <= rend_c;
					fend_q  <= fend_c;
					j_q     <= WW'(col_q) + WW'(1);
					tap_q   <= '0;
					state_q <= S_TAP;
				end
				S_TAP: begin
					if (tap_ok) begin
						prod_q     <= PW'(err_q) * PW'($signed({1'b0, tap_w}));
						tap_addr_q <= tap_addr;
						tap_buf_q  <= tap_buf;
						tap_fill_q <= tap_fill;
						state_q    <= S_SCALE;
					end else if (tap_last) begin
						state_q <= rend_q ? S_ROWCLR : S_DONE;
					end else begin
						tap_q <= tap_q + 4'd1;
					end
				end
				S_SCALE: begin
					if (use_shift_q) begin
						d_q     <= prod_q >>> divisor_q;
						state_q <= S_ADD;
					end else if (divisor_q == 8'd0) begin
						if (tap_last) begin
							state_q <= rend_q ? S_ROWCLR : S_DONE;
						end else begin
							tap_q   <= tap_q + 4'd1;
							state_q <= S_TAP;
						end
					end else begin
						dvd_q   <= DW'(mag_c);
						quo_q   <= '0;
						rem_q   <= '0;
						neg_q   <= prod_q[PW-1];
						cnt_q   <= '0;
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					dvd_q <= dvd_nx;
					quo_q <= quo_nx;
					rem_q <= rem_nx;
					cnt_q <= cnt_q + NW'(1);
					if (cnt_q == NW'(DSTEPS - 1)) begin
						d_q     <= neg_q ? -$signed(q_res) : $signed(q_res);
						state_q <= S_ADD;
					end
				end
				S_ADD: begin
					for (int b = 0; b < 3; b++) begin
						if (tap_buf_q == 2'(b) && fill_q[b] < tap_fill_q) begin
							fill_q[b] <= tap_fill_q;
						end
					end
					if (tap_last) begin
						state_q <= rend_q ? S_ROWCLR : S_DONE;
					end else begin
						tap_q   <= tap_q + 4'd1;
						state_q <= S_TAP;
					end
				end
				S_ROWCLR: begin
					if (rowclr_go) begin
						j_q <= j_q + WW'(1);
					end else begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (out_free) begin
						out_pixel_q <= pix_q;
						out_last_q  <= rend_q;
						out_user_q  <= fend_q;
						if (rend_q) begin
							for (int b = 0; b < 3; b++) begin
								if (row_sel_q == 2'(b)) begin
									fill_q[b] <= '0;
								end
							end
							col_q <= '0;
							if (fend_q) begin
								row_q     <= '0;
								row_sel_q <= '0;
							end else begin
								row_q     <= row_q + 16'd1;
								row_sel_q <= buf_next(row_sel_q);
							end
						end else begin
							col_q <= col_q + CW'(1);
						end
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

[rtl/core/edd_checker.sv]
// port-level checks for the error diffusion dither unit, with its bind
`include "assert_macros.svh"

module edd_port_checker (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      s_tvalid,
	input logic                      s_tready,
	input logic                      m_tvalid,
	input logic                      m_tready,
	input logic [edd_pkg::PIX_W-1:0] m_tdata,
	input logic                      m_tlast,
	input logic                      m_tuser
);
	import edd_pkg::*;

	// input side closes right after a beat is taken
	`EDD_ASSERT(a_busy_after_beat, clk, arst_n, s_tvalid && s_tready |=> !s_tready, "input taken while busy")

	// frame end only ever on a row end
	`EDD_ASSERT(a_frame_end_on_row_end, clk, arst_n, m_tvalid && m_tuser |-> m_tlast, "frame end without row end")

	// stalled result beat keeps its payload
	`EDD_ASSERT(a_out_hold, clk, arst_n, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast) && $stable(m_tuser), "stalled beat changed")

	// quiet while in reset
	`EDD_ASSERT_ALWAYS(a_reset_quiet, clk, !arst_n |-> !m_tvalid && !s_tready, "handshake active in reset")

endmodule

bind error_diffusion_dither_unit edd_port_checker u_edd_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tlast  (m_tlast),
	.m_tuser  (m_tuser)
);
